### hw/rtl/oebs_pkg.sv
// Package for the odd/even bit split codec: mode, operation and register codes,
// the stage-1 source select type, and the bit gather/scatter functions.
// No dependencies.
package oebs_pkg;

    // Depth of the half-block store
    localparam int OEBS_MAX_HALF = 256;

    // Register and field widths
    localparam int HALF_LEN_W = 9;
    localparam int WORD_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int PDATA_W    = 32;
    localparam int PADDR_W    = 3;

    // Register index codes (paddr bit 2 selects the register)
    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_HALF_LEN = 1'b1;

    // Mode codes
    localparam logic MODE_SPLIT = 1'b0;
    localparam logic MODE_JOIN  = 1'b1;

    // Operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Reset value of half_len
    localparam logic [HALF_LEN_W-1:0] HALF_LEN_RST = 9'd256;

    // Where the stage-1 result byte comes from
    typedef enum logic [1:0] {
        SRC_ODD,    // odd byte taken straight from the pushed word
        SRC_DRAIN,  // stored even byte read back from the store
        SRC_MERGE   // stored odd half merged with the incoming even byte
    } t_src;

    // Bits 15,13..1 of a word, MSB first
    function automatic logic [BYTE_W-1:0] odd_byte(input logic [WORD_W-1:0] w);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = w[2*i+1];
        end
        return r;
    endfunction

    // Bits 14,12..0 of a word, MSB first
    function automatic logic [BYTE_W-1:0] even_byte(input logic [WORD_W-1:0] w);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = w[2*i];
        end
        return r;
    endfunction

    // Interleave an odd and an even byte back into one word
    function automatic logic [WORD_W-1:0] merge_halves(input logic [BYTE_W-1:0] o,
                                                       input logic [BYTE_W-1:0] e);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[2*i+1] = o[i];
            r[2*i]   = e[i];
        end
        return r;
    endfunction

endpackage

### hw/rtl/oebs_store.sv
// Half-block byte store: one write port, one read port, registered read data.
// Uses oebs_pkg for the byte width.
module oebs_store
    import oebs_pkg::*;
#(
    parameter int DEPTH = OEBS_MAX_HALF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/odd_even_bit_split_codec_unit.sv
// Top level of the odd/even bit split and join codec.
// Depends on oebs_pkg and oebs_store.

// The codec takes one beat per cycle with no gaps while o_in_stall is low. A
// beat is decided in the cycle it is accepted: counters update and the half
// store is written or read at that edge. The store's registered read data
// joins the beat in the next stage, stage 1, and the result moves from stage 1
// into the output register when the output side can take it, so a result
// passes stage 1 and the output register before it shows on o_out_valid. Input
// stall rises only while the output register is full and stalled and the middle
// stage is occupied. A store entry written by one beat is readable by the very
// next beat, so no interlock is needed. Beats that give no result (drain with
// nothing stored, join first-half bytes, drains in join mode, join pushes with
// nothing left to pair) are still accepted. There is no clearing pass after
// reset; configuration must be written only while the block is idle.
module odd_even_bit_split_codec_unit
    import oebs_pkg::*;
#(
    parameter int MAX_HALF = OEBS_MAX_HALF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [WORD_W-1:0]  i_data_in,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [WORD_W-1:0]  o_data_out,
    output logic               o_last,
    output logic               o_overflow,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_HALF);
    localparam int CW = $clog2(MAX_HALF + 1);
    localparam int XW = (CW > HALF_LEN_W) ? CW : HALF_LEN_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_HALF);
    localparam logic [XW-1:0] MAX_X = XW'(MAX_HALF);

    // Configuration registers
    logic                  r_mode;
    logic [HALF_LEN_W-1:0] r_half_len;

    // Block state
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_rptr, n_rptr;
    logic          r_second, n_second;

    // Stage 1 (waits on store read data)
    logic              r_s1_valid;
    t_src              r_s1_src, n_s1_src;
    logic [BYTE_W-1:0] r_s1_byte, n_s1_byte;
    logic              r_s1_last, n_s1_last;
    logic              r_s1_ovf, n_s1_ovf;
    logic              n_s1_res;

    // Output register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_data, n_out_data;
    logic              r_out_last;
    logic              r_out_ovf;

    // Store ports
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;

    logic          in_acc;
    logic          out_take;
    logic          s1_move;
    logic          cfg_wr;
    logic [XW-1:0] hl_x;
    logic [XW-1:0] eff_x;
    logic [CW-1:0] fill_inc;
    logic [CW-1:0] rptr_inc;

    // Handshake
    assign out_take   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_take;
    assign o_in_stall = r_s1_valid && !out_take;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_SPLIT;
            r_half_len <= HALF_LEN_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MODE:     r_mode     <= pwdata[0];
                REG_HALF_LEN: r_half_len <= pwdata[HALF_LEN_W-1:0];
                default:      r_mode     <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MODE:     prdata = PDATA_W'(r_mode);
            REG_HALF_LEN: prdata = PDATA_W'(r_half_len);
            default:      prdata = '0;
        endcase
    end

    // Effective half length, saturated into 1..MAX_HALF
    assign hl_x  = XW'(r_half_len);
    assign eff_x = (r_half_len == '0) ? XW'(1) : ((hl_x > MAX_X) ? MAX_X : hl_x);

    assign fill_inc = r_fill + 1'b1;
    assign rptr_inc = r_rptr + 1'b1;

    // Beat decode: counter updates, store access, stage-1 payload
    always_comb begin
        n_fill    = r_fill;
        n_rptr    = r_rptr;
        n_second  = r_second;
        wr_en     = 1'b0;
        wr_addr   = r_fill[AW-1:0];
        wr_data   = even_byte(i_data_in);
        rd_en     = 1'b0;
        n_s1_res  = 1'b0;
        n_s1_src  = SRC_ODD;
        n_s1_byte = odd_byte(i_data_in);
        n_s1_last = 1'b0;
        n_s1_ovf  = 1'b0;
        if (in_acc) begin
            case (r_mode)
                MODE_SPLIT: begin
                    if (i_operation == OP_PUSH) begin
                        // odd byte out now, even byte into the store while it has room
                        n_s1_res = 1'b1;
                        if (r_fill < MAX_C) begin
                            wr_en  = 1'b1;
                            n_fill = fill_inc;
                        end else begin
                            n_s1_ovf = 1'b1;
                        end
                    end else if (r_rptr < r_fill && r_rptr < MAX_C) begin
                        // drain one stored even byte
                        n_s1_res = 1'b1;
                        n_s1_src = SRC_DRAIN;
                        rd_en    = 1'b1;
                        n_rptr   = rptr_inc;
                        if (rptr_inc >= r_fill) begin
                            n_s1_last = 1'b1;
                            n_fill    = '0;
                            n_rptr    = '0;
                        end
                    end
                end
                MODE_JOIN: begin
                    wr_data = i_data_in[BYTE_W-1:0];
                    if (i_operation != OP_PUSH) begin
                        n_s1_res = 1'b0;
                    end else if (!r_second) begin
                        // first half: store the odd byte
                        if (r_fill < MAX_C) begin
                            wr_en  = 1'b1;
                            n_fill = fill_inc;
                        end
                        if (XW'(n_fill) >= eff_x || n_fill >= MAX_C) begin
                            n_second = 1'b1;
                            n_rptr   = '0;
                        end
                    end else if (r_rptr < r_fill && r_rptr < MAX_C) begin
                        // second half: pair with the stored partner
                        n_s1_res  = 1'b1;
                        n_s1_src  = SRC_MERGE;
                        n_s1_byte = i_data_in[BYTE_W-1:0];
                        rd_en     = 1'b1;
                        n_rptr    = rptr_inc;
                        if (rptr_inc >= r_fill) begin
                            n_s1_last = 1'b1;
                            n_fill    = '0;
                            n_rptr    = '0;
                            n_second  = 1'b0;
                        end
                    end else begin
                        // nothing left to pair: drop and restart the block
                        n_fill   = '0;
                        n_rptr   = '0;
                        n_second = 1'b0;
                    end
                end
                default: n_s1_res = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_rptr   <= '0;
            r_second <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_rptr   <= n_rptr;
            r_second <= n_second;
        end
    end

    // Half store
    oebs_store #(
        .DEPTH (MAX_HALF)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rptr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Stage 1 control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || s1_move) begin
            r_s1_valid <= in_acc && n_s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_src  <= n_s1_src;
            r_s1_byte <= n_s1_byte;
            r_s1_last <= n_s1_last;
            r_s1_ovf  <= n_s1_ovf;
        end
    end

    // Result word from stage 1
    always_comb begin
        case (r_s1_src)
            SRC_ODD:   n_out_data = WORD_W'(r_s1_byte);
            SRC_DRAIN: n_out_data = WORD_W'(rd_data);
            SRC_MERGE: n_out_data = merge_halves(rd_data, r_s1_byte);
            default:   n_out_data = '0;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s1_last;
            r_out_ovf  <= r_s1_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_last      = r_out_last;
    assign o_overflow  = r_out_ovf;

endmodule

### hw/rtl/oebs_checker.sv
// Port-level checks for odd_even_bit_split_codec_unit, attached by bind.
// No package dependencies.
module oebs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_data_out,
    input logic        o_last,
    input logic        o_overflow,
    input logic        pready
);

    // A beat never carries both the last mark and an overflow
    a_last_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_last && o_overflow))
        else $error("last and overflow on the same beat");

    // Input stalls only when the output side is full and held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // Overflow beats keep the upper byte clear
    a_ovf_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_data_out[15:8] == 8'h00))
        else $error("overflow beat with a full word");

    // Output beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_data_out)))
        else $error("stalled output beat changed");

    // No output beat right out of reset, config port never waits
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && pready))
        else $error("output active right after reset");

endmodule

bind odd_even_bit_split_codec_unit oebs_checker u_oebs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_data_out  (o_data_out),
    .o_last      (o_last),
    .o_overflow  (o_overflow),
    .pready      (pready)
);

### test/tb_top.sv
// Self-checking bench for odd_even_bit_split_codec_unit: directed table plus random
// split/join traffic, each result scored against a local bit-level codec model or the table.
// Depends on oebs_pkg and the codec RTL.
module tb_top
    import oebs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int HALF_DEPTH    = OEBS_MAX_HALF;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    // One result beat as the codec emits it
    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic              last;
        logic              ovf;
    } t_codec_result;

    typedef enum logic [1:0] {
        ROW_CFG,      // register write, issued only when idle
        ROW_BEAT,     // input beat scored by the model
        ROW_CHECKED   // input beat with its result written in the table
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic              reg_sel;
        logic [8:0]        cfg_val;
        logic              op;
        logic [WORD_W-1:0] din;
        t_codec_result     want;
    } t_dir_row;

    // DUT signals
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic               i_operation = OP_PUSH;
    logic [WORD_W-1:0]  i_data_in   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [WORD_W-1:0]  o_data_out;
    logic               o_last;
    logic               o_overflow;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Model of the codec state and its registers
    logic [BYTE_W-1:0]     half_mem [HALF_DEPTH];
    int                    fill_cnt   = 0;
    int                    rd_idx     = 0;
    logic                  second_q   = 1'b0;
    logic                  mode_q     = MODE_SPLIT;
    logic [HALF_LEN_W-1:0] half_len_q = HALF_LEN_RST;

    t_codec_result pending_results [$];
    t_dir_row      dir_rows [$];
    int            mismatches    = 0;
    int            beats_taken   = 0;
    int            cycle_count   = 0;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;

    odd_even_bit_split_codec_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out),
        .o_last      (o_last),
        .o_overflow  (o_overflow),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Gather bits 15,13..1 (MSB first)
    function automatic logic [BYTE_W-1:0] odd_of(input logic [WORD_W-1:0] w);
        logic [BYTE_W-1:0] b;
        b = '0;
        for (int k = BYTE_W - 1; k >= 0; k--) b = {b[BYTE_W-2:0], w[2*k+1]};
        return b;
    endfunction

    // Gather bits 14,12..0 (MSB first)
    function automatic logic [BYTE_W-1:0] even_of(input logic [WORD_W-1:0] w);
        logic [BYTE_W-1:0] b;
        b = '0;
        for (int k = BYTE_W - 1; k >= 0; k--) b = {b[BYTE_W-2:0], w[2*k]};
        return b;
    endfunction

    // Rebuild a word from its odd and even bytes
    function automatic logic [WORD_W-1:0] weave(input logic [BYTE_W-1:0] o,
                                                input logic [BYTE_W-1:0] e);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int k = BYTE_W - 1; k >= 0; k--) w = {w[WORD_W-3:0], o[k], e[k]};
        return w;
    endfunction

    function automatic int clamp_half(input logic [HALF_LEN_W-1:0] hl);
        int eff;
        eff = int'(hl);
        if (eff < 1) eff = 1;
        if (eff > HALF_DEPTH) eff = HALF_DEPTH;
        return eff;
    endfunction

    // Advance the codec model by one accepted beat; returns 1 when a result is due
    function automatic bit codec_predict(input logic op, input logic [WORD_W-1:0] d,
                                         output t_codec_result r);
        r = '0;
        if (mode_q == MODE_SPLIT) begin
            if (op == OP_PUSH) begin
                r.data = {8'h00, odd_of(d)};
                if (fill_cnt < HALF_DEPTH) begin
                    half_mem[fill_cnt] = even_of(d);
                    fill_cnt++;
                end else begin
                    r.ovf = 1'b1;
                end
                return 1'b1;
            end
            if (rd_idx >= fill_cnt || rd_idx >= HALF_DEPTH) return 1'b0;
            r.data = {8'h00, half_mem[rd_idx]};
            rd_idx++;
            if (rd_idx >= fill_cnt) begin
                r.last   = 1'b1;
                fill_cnt = 0;
                rd_idx   = 0;
            end
            return 1'b1;
        end
        // join mode: drains are ignored
        if (op != OP_PUSH) return 1'b0;
        if (!second_q) begin
            if (fill_cnt < HALF_DEPTH) begin
                half_mem[fill_cnt] = d[7:0];
                fill_cnt++;
            end
            if (fill_cnt >= clamp_half(half_len_q) || fill_cnt >= HALF_DEPTH) begin
                second_q = 1'b1;
                rd_idx   = 0;
            end
            return 1'b0;
        end
        if (rd_idx >= fill_cnt || rd_idx >= HALF_DEPTH) begin
            fill_cnt = 0;
            rd_idx   = 0;
            second_q = 1'b0;
            return 1'b0;
        end
        r.data = weave(half_mem[rd_idx], d[7:0]);
        rd_idx++;
        if (rd_idx >= fill_cnt) begin
            r.last   = 1'b1;
            fill_cnt = 0;
            rd_idx   = 0;
            second_q = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] corner [4];
        corner = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
        if ($urandom_range(0, 9) == 0) return corner[$urandom_range(0, 3)];
        return WORD_W'($urandom_range(0, 65535));
    endfunction

    // Table row builders
    function automatic t_dir_row row_cfg(input logic sel, input logic [8:0] val);
        t_dir_row r;
        r = '0;
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic t_dir_row row_beat(input logic op, input logic [WORD_W-1:0] d);
        t_dir_row r;
        r = '0;
        r.kind = ROW_BEAT;
        r.op   = op;
        r.din  = d;
        return r;
    endfunction

    function automatic t_dir_row row_chk(input logic op, input logic [WORD_W-1:0] d,
                                         input logic [WORD_W-1:0] q, input logic lst,
                                         input logic ovf);
        t_dir_row r;
        r = '0;
        r.kind      = ROW_CHECKED;
        r.op        = op;
        r.din       = d;
        r.want.data = q;
        r.want.last = lst;
        r.want.ovf  = ovf;
        return r;
    endfunction

    // Present one input beat, optionally after random idle cycles, until accepted
    task automatic send_beat(input logic op, input logic [WORD_W-1:0] d, input bit typed,
                             input t_codec_result typed_res);
        t_codec_result r;
        bit has;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_in   <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        has = codec_predict(op, d, r);
        if (typed) pending_results.push_back(typed_res);
        else if (has) pending_results.push_back(r);
        if (!(mode_q == MODE_JOIN && op == OP_DRAIN)) beats_taken++;
    endtask

    // Hold off input until every expected result is out, then let the pipe settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic cfg_write(input logic sel, input logic [8:0] val);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {23'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_MODE) mode_q = val[0];
        else half_len_q = val;
    endtask

    task automatic pick_config();
        logic [8:0] wide_lens [4];
        int roll;
        wide_lens = '{9'd255, 9'd256, 9'd257, 9'd511};
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            cfg_write(REG_MODE, {8'd0, ~mode_q});
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 80) cfg_write(REG_HALF_LEN, 9'($urandom_range(1, 8)));
            else if (roll < 90) cfg_write(REG_HALF_LEN, 9'($urandom_range(0, 1)));
            else if (roll < 95) cfg_write(REG_HALF_LEN, 9'($urandom_range(9, 40)));
            else cfg_write(REG_HALF_LEN, wide_lens[$urandom_range(0, 3)]);
        end
    endtask

    // Mostly well-formed split bursts and join blocks, some noise and cut-short blocks
    task automatic run_random(input int beat_budget);
        int stop_at;
        int roll;
        int n;
        int eff;
        stop_at = beats_taken + beat_budget;
        while (beats_taken < stop_at) begin
            if ($urandom_range(0, 3) == 0) pick_config();
            roll = $urandom_range(0, 9);
            if (roll >= 8) begin
                n = $urandom_range(1, 10);
                repeat (n) send_beat(1'($urandom_range(0, 1)), pick_word(), 1'b0, '0);
            end else if (mode_q == MODE_SPLIT) begin
                n = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 262)
                                                  : $urandom_range(1, 8);
                repeat (n) send_beat(OP_PUSH, pick_word(), 1'b0, '0);
                repeat (n + $urandom_range(0, 1)) send_beat(OP_DRAIN, pick_word(), 1'b0, '0);
            end else begin
                eff = clamp_half(half_len_q);
                n = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 2 * eff + 2) : 2 * eff;
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0) send_beat(OP_DRAIN, pick_word(), 1'b0, '0);
                    send_beat(OP_PUSH, pick_word(), 1'b0, '0);
                end
            end
            if ($urandom_range(0, 29) == 0) wait_drained();
        end
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Score each accepted result beat against the oldest expectation
    always @(posedge i_clk) begin : score
        t_codec_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat: data_out=%h last=%b overflow=%b",
                         $time, o_data_out, o_last, o_overflow);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_data_out !== want.data) begin
                    $display("%0t: data_out expected %h actual %h",
                             $time, want.data, o_data_out);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, o_last);
                    mismatches++;
                end
                if (o_overflow !== want.ovf) begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.ovf, o_overflow);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        // Split mode after reset: extremes, empty drain, last-byte drain
        dir_rows.push_back(row_beat(OP_DRAIN, 16'h0000));
        dir_rows.push_back(row_chk(OP_PUSH,  16'hFFFF, 16'h00FF, 1'b0, 1'b0));
        dir_rows.push_back(row_chk(OP_PUSH,  16'h0000, 16'h0000, 1'b0, 1'b0));
        dir_rows.push_back(row_chk(OP_PUSH,  16'hAAAA, 16'h00FF, 1'b0, 1'b0));
        dir_rows.push_back(row_chk(OP_PUSH,  16'h5555, 16'h0000, 1'b0, 1'b0));
        dir_rows.push_back(row_chk(OP_DRAIN, 16'hFFFF, 16'h00FF, 1'b0, 1'b0));
        dir_rows.push_back(row_chk(OP_DRAIN, 16'h0000, 16'h0000, 1'b0, 1'b0));
        dir_rows.push_back(row_chk(OP_DRAIN, 16'h1234, 16'h0000, 1'b0, 1'b0));
        dir_rows.push_back(row_chk(OP_DRAIN, 16'h0000, 16'h00FF, 1'b1, 1'b0));
        dir_rows.push_back(row_beat(OP_DRAIN, 16'hFFFF));
        // Join with one-byte halves; drain ignored, upper bits ignored
        dir_rows.push_back(row_cfg(REG_HALF_LEN, 9'd1));
        dir_rows.push_back(row_cfg(REG_MODE, {8'd0, MODE_JOIN}));
        dir_rows.push_back(row_beat(OP_DRAIN, 16'h1234));
        dir_rows.push_back(row_beat(OP_PUSH,  16'hFF00));
        dir_rows.push_back(row_chk(OP_PUSH,   16'h00FF, 16'h5555, 1'b1, 1'b0));
        // half_len of zero acts as one
        dir_rows.push_back(row_cfg(REG_HALF_LEN, 9'd0));
        dir_rows.push_back(row_beat(OP_PUSH,  16'h00FF));
        dir_rows.push_back(row_chk(OP_PUSH,   16'hAB00, 16'hAAAA, 1'b1, 1'b0));
        // Three-byte halves
        dir_rows.push_back(row_cfg(REG_HALF_LEN, 9'd3));
        dir_rows.push_back(row_beat(OP_PUSH, 16'hC3A5));
        dir_rows.push_back(row_beat(OP_PUSH, 16'h6666));
        dir_rows.push_back(row_beat(OP_PUSH, 16'h8001));
        dir_rows.push_back(row_beat(OP_PUSH, 16'h3C3C));
        dir_rows.push_back(row_beat(OP_PUSH, 16'hFFFF));
        dir_rows.push_back(row_beat(OP_PUSH, 16'h7E00));
        // Mode change mid-block, then join second half with nothing stored
        dir_rows.push_back(row_cfg(REG_HALF_LEN, 9'd1));
        dir_rows.push_back(row_beat(OP_PUSH, 16'h005A));
        dir_rows.push_back(row_cfg(REG_MODE, {8'd0, MODE_SPLIT}));
        dir_rows.push_back(row_chk(OP_DRAIN, 16'h0000, 16'h005A, 1'b1, 1'b0));
        dir_rows.push_back(row_cfg(REG_MODE, {8'd0, MODE_JOIN}));
        dir_rows.push_back(row_beat(OP_PUSH, 16'h0077));
        dir_rows.push_back(row_beat(OP_PUSH, 16'h0011));
        dir_rows.push_back(row_beat(OP_PUSH, 16'h0022));
        dir_rows.push_back(row_cfg(REG_MODE, {8'd0, MODE_SPLIT}));
        dir_rows.push_back(row_cfg(REG_HALF_LEN, 9'd256));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase 0: sender idles little, receiver stalls a lot
        send_idle_pct = 23;
        stall_pct     = 77;
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG:  cfg_write(dir_rows[i].reg_sel, dir_rows[i].cfg_val);
                ROW_BEAT: send_beat(dir_rows[i].op, dir_rows[i].din, 1'b0, '0);
                default:  send_beat(dir_rows[i].op, dir_rows[i].din, 1'b1, dir_rows[i].want);
            endcase
        end
        run_random(220);
        wait_drained();

        // Phase 1: roles swapped
        send_idle_pct = 77;
        stall_pct     = 23;
        run_random(220);
        wait_drained();

        // Phase 2: full rate; start from an empty block, then overflow the store
        send_idle_pct = 0;
        stall_pct     = 0;
        cfg_write(REG_MODE, {8'd0, MODE_SPLIT});
        while (fill_cnt != 0) send_beat(OP_DRAIN, pick_word(), 1'b0, '0);
        if (second_q) begin
            cfg_write(REG_MODE, {8'd0, MODE_JOIN});
            send_beat(OP_PUSH, pick_word(), 1'b0, '0);
            cfg_write(REG_MODE, {8'd0, MODE_SPLIT});
        end
        repeat (HALF_DEPTH + 2) send_beat(OP_PUSH, pick_word(), 1'b0, '0);
        // Join on a full store: first byte dropped, then every stored byte paired
        cfg_write(REG_MODE, {8'd0, MODE_JOIN});
        repeat (HALF_DEPTH + 1) send_beat(OP_PUSH, pick_word(), 1'b0, '0);
        // Largest half_len saturates to the store depth
        cfg_write(REG_HALF_LEN, 9'd511);
        repeat (2 * HALF_DEPTH) send_beat(OP_PUSH, pick_word(), 1'b0, '0);
        run_random(100);

        wait_drained();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
